### rtl/sbha_pkg.sv
// ----------------------------------------------------------------------------
// Spectrum bin history averager package
// Shared widths, constants and payload types of the averager blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package sbha_pkg;

  // Field widths of the request and result items.
  localparam int unsigned BIN_W   = 9;
  localparam int unsigned POWER_W = 32;
  localparam int unsigned IDLE_W  = 16;

  // History depth is fixed, so the average is a plain right shift.
  localparam int unsigned HIST_DEPTH = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned SUM_W      = POWER_W + SLOT_W;

  // Idle counter saturation value and idle_frames reset value.
  localparam logic [IDLE_W-1:0] IDLE_MAX        = 16'hFFFF;
  localparam logic [IDLE_W-1:0] IDLE_FRAMES_RST = 16'd128;

  // Depths of the command queue and of the result queue.
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;

  // One input request.
  typedef struct packed {
    logic [BIN_W-1:0]   bin_index;
    logic [POWER_W-1:0] power;
    logic               frame_start;
    logic               frame_end;
    logic               receiving;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [BIN_W-1:0]   bin_out;
    logic [POWER_W-1:0] average;
    logic               frame_last;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic               clear;
    logic [SLOT_W-1:0]  slot;
    logic [BIN_W-1:0]   bin;
    logic [POWER_W-1:0] power;
    logic               in_range;
    logic               frame_last;
  } cmd_t;

  // Status reported by the back to the front.
  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage : sbha_pkg

`default_nettype wire

### rtl/sbha_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sbha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : sbha_ram

`default_nettype wire

### rtl/sbha_fifo.sv
// ----------------------------------------------------------------------------
// Small register FIFO
// Register-based first-in first-out queue with fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module sbha_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       pop_i,
  output      logic [WIDTH-1:0]           rdata_o,
  output      logic                       full_o,
  output      logic                       empty_o,
  output      logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage holds payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule : sbha_fifo

`default_nettype wire

### rtl/sbha_front.sv
// ----------------------------------------------------------------------------
// Averager front end
// Accepts requests, runs the idle counter and history slot, and issues
// classified commands into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sbha_front
  import sbha_pkg::*;
#(
  parameter int unsigned BINS = 512
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [IDLE_W-1:0]  cfg_data_i,
  input  wire logic               push,
  output      logic               full,
  input  wire in_item_t           item_i,
  input  wire back_status_t       status_i,
  input  wire logic               cmd_full_i,
  output      logic               cmd_push_o,
  output      cmd_t               cmd_o
);

  logic [IDLE_W-1:0] idle_frames_q;
  logic [IDLE_W-1:0] idle_q, idle_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              accept;
  logic              clear;

  assign cfg_ready_o = 1'b1;
  assign full        = cmd_full_i || status_i.init_busy;
  assign accept      = push && !full;

  // Idle counting on the first bin of a frame; a clear fires only when the
  // count steps onto idle_frames.
  always_comb begin
    idle_d = idle_q;
    clear  = 1'b0;
    if (item_i.frame_start) begin
      if (item_i.receiving) begin
        idle_d = '0;
      end else if (idle_q != IDLE_MAX) begin
        idle_d = idle_q + 1'b1;
        clear  = (idle_d == idle_frames_q);
      end
    end
  end

  // The slot advances after the last bin of a frame.
  always_comb begin
    slot_d = slot_q;
    if (item_i.frame_end) begin
      slot_d = (slot_q == SLOT_W'(HIST_DEPTH - 1)) ? '0 : slot_q + 1'b1;
    end
  end

  // Front state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_frames_q <= IDLE_FRAMES_RST;
      idle_q        <= '0;
      slot_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        idle_frames_q <= cfg_data_i;
      end
      if (accept) begin
        idle_q <= idle_d;
        slot_q <= slot_d;
      end
    end
  end

  // Command towards the back end.
  assign cmd_push_o       = accept;
  assign cmd_o.clear      = clear;
  assign cmd_o.slot       = slot_q;
  assign cmd_o.bin        = item_i.bin_index;
  assign cmd_o.power      = item_i.power;
  assign cmd_o.in_range   = (32'(item_i.bin_index) < 32'(BINS));
  assign cmd_o.frame_last = item_i.frame_end;

endmodule : sbha_front

`default_nettype wire

### rtl/sbha_back.sv
// ----------------------------------------------------------------------------
// Averager back end
// Read-modify-write of the sum and history memories, clearing sweeps and
// the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sbha_back
  import sbha_pkg::*;
#(
  parameter int unsigned BINS = 512
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cmd_empty_i,
  output      logic         cmd_pop_o,
  input  wire cmd_t         cmd_i,
  output      back_status_t status_o,
  output      logic         empty,
  input  wire logic         pop,
  output      out_item_t    result_o
);

  localparam int unsigned AW = $clog2(BINS);
  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);

  // Sequencer states.
  localparam logic [1:0] ST_INIT_SWEEP  = 2'd0;
  localparam logic [1:0] ST_RUN         = 2'd1;
  localparam logic [1:0] ST_CLEAR_SWEEP = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [AW-1:0]      sweep_addr_q;
  logic               sweep_last;
  logic               sweeping;
  logic               swept_q;

  cmd_t               c_q;
  logic               c_valid_q;
  logic [AW-1:0]      c_addr;
  logic               c_write;

  logic               lw_valid_q;
  logic [AW-1:0]      lw_addr_q;
  logic [SLOT_W-1:0]  lw_slot_q;
  logic [POWER_W-1:0] lw_power_q;
  logic [SUM_W-1:0]   lw_sum_q;

  logic [SUM_W-1:0]   sum_rdata;
  logic [POWER_W-1:0] hist_rdata [HIST_DEPTH];
  logic [SUM_W-1:0]   sum_old;
  logic [POWER_W-1:0] hist_old;
  logic [SUM_W-1:0]   sum_new;

  logic [AW-1:0]      waddr;
  logic [OCW-1:0]     out_count;
  logic               out_room;
  out_item_t          out_item;

  assign sweeping   = (state_q != ST_RUN);
  assign sweep_last = (sweep_addr_q == AW'(BINS - 1));
  assign status_o.init_busy = (state_q == ST_INIT_SWEEP);

  // A command may issue only if its result is sure of a queue slot.
  assign out_room  = (32'(out_count) + 32'(c_valid_q)) < OUT_DEPTH;
  assign cmd_pop_o = (state_q == ST_RUN) && !cmd_empty_i &&
                     (!cmd_i.clear || swept_q) && out_room;

  // Sequencer: reset sweep, then run; a clear command first sweeps.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT_SWEEP: begin
        if (sweep_last) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (!cmd_empty_i && cmd_i.clear && !swept_q) state_d = ST_CLEAR_SWEEP;
      end
      ST_CLEAR_SWEEP: begin
        if (sweep_last) state_d = ST_RUN;
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT_SWEEP;
      sweep_addr_q <= '0;
      swept_q      <= 1'b0;
      c_valid_q    <= 1'b0;
      lw_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (sweeping) begin
        sweep_addr_q <= sweep_last ? '0 : sweep_addr_q + 1'b1;
      end
      if (state_q == ST_CLEAR_SWEEP && sweep_last) begin
        swept_q <= 1'b1;
      end else if (cmd_pop_o) begin
        swept_q <= 1'b0;
      end
      c_valid_q <= cmd_pop_o;
      if (sweeping) begin
        lw_valid_q <= 1'b0;
      end else if (c_write) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  // Payload of the compute stage and of the last write.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      c_q <= cmd_i;
    end
    if (c_write) begin
      lw_addr_q  <= c_addr;
      lw_slot_q  <= c_q.slot;
      lw_power_q <= c_q.power;
      lw_sum_q   <= sum_new;
    end
  end

  assign c_addr  = AW'(c_q.bin);
  assign c_write = c_valid_q && c_q.in_range;

  // The previous write lands after this read was taken, so forward it.
  always_comb begin
    sum_old  = sum_rdata;
    hist_old = hist_rdata[c_q.slot];
    if (lw_valid_q && lw_addr_q == c_addr) begin
      sum_old = lw_sum_q;
      if (lw_slot_q == c_q.slot) begin
        hist_old = lw_power_q;
      end
    end
  end

  // Exact running sum update; the average is the sum shifted right.
  assign sum_new = sum_old - SUM_W'(hist_old) + SUM_W'(c_q.power);

  assign waddr = sweeping ? sweep_addr_q : c_addr;

  // Running sum memory.
  sbha_ram #(
    .WIDTH (SUM_W),
    .DEPTH (BINS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sweeping || c_write),
    .waddr_i (waddr),
    .wdata_i (sweeping ? '0 : sum_new),
    .raddr_i (AW'(cmd_i.bin)),
    .rdata_o (sum_rdata)
  );

  // One history memory for each slot, all addressed by bin.
  for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_hist
    sbha_ram #(
      .WIDTH (POWER_W),
      .DEPTH (BINS)
    ) u_hist_ram (
      .clk_i   (clk_i),
      .we_i    (sweeping || (c_write && c_q.slot == SLOT_W'(k))),
      .waddr_i (waddr),
      .wdata_i (sweeping ? '0 : c_q.power),
      .raddr_i (AW'(cmd_i.bin)),
      .rdata_o (hist_rdata[k])
    );
  end

  // Result assembly.
  assign out_item.bin_out    = c_q.bin;
  assign out_item.average    = c_q.in_range ? sum_new[SUM_W-1:SLOT_W] : '0;
  assign out_item.frame_last = c_q.frame_last;

  // Result queue; the issue check keeps it from overflowing.
  sbha_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (c_valid_q),
    .wdata_i (out_item),
    .pop_i   (pop),
    .rdata_o (result_o),
    .full_o  (),
    .empty_o (empty),
    .count_o (out_count)
  );

endmodule : sbha_back

`default_nettype wire

### rtl/spectrum_bin_history_averager.sv
// Path: a request goes through the command queue, the compute stage register
// and the result queue. Throughput: one request per cycle while the result
// queue has room, set by the pipelined read-modify-write of the sum and
// history memories; an idle clear stalls the back end while it sweeps the
// memories, while intake carries on until the command queue fills.
// Reset: a clearing pass zeroes the memories, with full held.
// ----------------------------------------------------------------------------
// Spectrum bin history averager
// Per-bin boxcar moving average of power spectra over the last frames.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_bin_history_averager
  import sbha_pkg::*;
#(
  parameter int unsigned BINS = 512
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [IDLE_W-1:0] cfg_data_i,
  input  wire logic              push,
  output      logic              full,
  input  wire in_item_t          item_i,
  output      logic              empty,
  input  wire logic              pop,
  output      out_item_t         result_o
);

  back_status_t status;
  logic         cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t         cmd_in, cmd_head;

  // Request intake and classification.
  sbha_front #(
    .BINS (BINS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .status_i    (status),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  // Command queue between front and back.
  sbha_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .full_o  (cmd_full),
    .empty_o (cmd_empty),
    .count_o ()
  );

  // Memory update and result delivery.
  sbha_back #(
    .BINS (BINS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd_head),
    .status_o    (status),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule : spectrum_bin_history_averager

`default_nettype wire

### rtl/sbha_checker.sv
// ----------------------------------------------------------------------------
// Averager port checker
// Watches the top-level ports for ordering and occupancy slips.
// ----------------------------------------------------------------------------
`default_nettype none

module sbha_checker
  import sbha_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              cfg_valid_i,
  input wire logic              cfg_ready_o,
  input wire logic              push,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire out_item_t         result_o
);

  // Requests in flight: command queue, compute stage and result queue.
  localparam int unsigned MAX_PENDING = CMD_DEPTH + 1 + OUT_DEPTH;

  logic [3:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  // Count of accepted requests whose result is not yet taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  // No result appears without an outstanding request.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pending_q != 4'd0))
    else $error("result shown with no request outstanding");

  // Occupancy never exceeds the storage of the block.
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pending_q) <= MAX_PENDING)
    else $error("more requests in flight than the block can hold");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result changed or vanished");

  // The configuration port never stalls.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write not taken");

endmodule : sbha_checker

bind spectrum_bin_history_averager sbha_checker u_checker (.*);

`default_nettype wire

### verif/spectrum_bin_history_averager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum bin history averager testbench
// Drives framed power bins through the push side of the averager and pops its
// averages, checking each one against a cycle-free model of the per-bin
// boxcar history, idle counter and clear. A short table of hand-picked
// requests runs first, then framed random traffic under several idle_frames
// settings, including a run of quiet frames that reaches the clear threshold.
// ----------------------------------------------------------------------------

module spectrum_bin_history_averager_tb;
  import sbha_pkg::*;

  localparam int unsigned BINS_N = 512;
  // The bound sits well above the slowest correct run, even with every clear
  // pass and every long stall.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  // One row of the directed table: the request and, where typed, its average.
  typedef struct {
    in_item_t           stim;
    bit                 typed;
    logic [POWER_W-1:0] avg;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [IDLE_W-1:0]  cfg_data_i  = '0;
  logic               push        = 1'b0;
  logic               full;
  in_item_t           item_i      = '0;
  logic               empty;
  logic               pop         = 1'b0;
  out_item_t          result_o;

  // Model state of the averager.
  logic [POWER_W-1:0] bin_history [HIST_DEPTH][BINS_N];
  logic [SUM_W-1:0]   bin_sums [BINS_N];
  logic [SLOT_W-1:0]  hist_slot;
  logic [IDLE_W-1:0]  idle_run;
  logic [IDLE_W-1:0]  idle_frames_q;

  out_item_t          pending_averages [$];
  dir_row_t           directed_bins [$];
  int unsigned        mismatches  = 0;
  int unsigned        cycle_count = 0;
  bit                 tx_calm     = 1'b0;
  bit                 rx_calm     = 1'b0;
  bit                 soak_mode   = 1'b0;
  int                 rx_stall_left = 0;

  spectrum_bin_history_averager #(
    .BINS(BINS_N)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

  // Free-running clock, 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Zero every history word and every running sum.
  function automatic void wipe_history();
    for (int b = 0; b < BINS_N; b++) begin
      bin_sums[b] = '0;
      for (int d = 0; d < HIST_DEPTH; d++) begin
        bin_history[d][b] = '0;
      end
    end
  endfunction

  // Advance the model by one request and return the average it produces.
  function automatic out_item_t average_bin(in_item_t it);
    out_item_t        res;
    logic [SUM_W-1:0] acc;
    logic [SUM_W-1:0] quot;
    // Frame start handling comes first: idle count and a possible clear.
    if (it.frame_start) begin
      if (it.receiving) begin
        idle_run = '0;
      end else if (idle_run != IDLE_MAX) begin
        idle_run = idle_run + 1'b1;
        if (idle_run == idle_frames_q) wipe_history();
      end
    end
    // Replace the oldest value of the bin and keep the sum exact.
    acc = bin_sums[it.bin_index] - SUM_W'(bin_history[hist_slot][it.bin_index])
          + SUM_W'(it.power);
    bin_sums[it.bin_index] = acc;
    bin_history[hist_slot][it.bin_index] = it.power;
    quot = acc / HIST_DEPTH;
    // The slot moves on after the last bin of a frame.
    if (it.frame_end) hist_slot = hist_slot + 1'b1;
    res.bin_out    = it.bin_index;
    res.average    = quot[POWER_W-1:0];
    res.frame_last = it.frame_end;
    return res;
  endfunction

  // Idle length: mostly a few cycles, now and then a long one.
  function automatic int pick_gap();
    if (!soak_mode && $urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Power values weighted towards the edges of the range.
  function automatic logic [POWER_W-1:0] pick_power();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return POWER_W'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  function automatic dir_row_t dir_row(int unsigned bin, logic [POWER_W-1:0] pw, bit fs,
                                       bit fe, bit rx, bit typed, logic [POWER_W-1:0] avg);
    dir_row_t r;
    r.stim.bin_index   = BIN_W'(bin);
    r.stim.power       = pw;
    r.stim.frame_start = fs;
    r.stim.frame_end   = fe;
    r.stim.receiving   = rx;
    r.typed            = typed;
    r.avg              = avg;
    return r;
  endfunction

  // Offer one request, wait for it to be taken and record its expected average.
  task automatic send_bin(in_item_t it);
    int gap;
    gap = 0;
    if (!soak_mode && !tx_calm && $urandom_range(99) < 25) gap = pick_gap();
    if ($urandom_range(39) == 0) tx_calm = !tx_calm;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_averages.push_back(average_bin(it));
  endtask

  // Hold the push side idle until every expected average has come out.
  task automatic settle_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_averages.size() != 0) @(posedge clk_i);
  endtask

  // Write idle_frames once the block has gone quiet.
  task automatic set_idle_frames(logic [IDLE_W-1:0] value);
    settle_results();
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    idle_frames_q = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Framed traffic with random content, salted with noise and broken frames.
  task automatic run_frames(int n_items, int rx_pct, int span);
    in_item_t it;
    int       sent;
    int       len;
    int       base;
    bit       rx;
    bit       broken;
    bit       drop_start;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        // A lone request with random flags anywhere in the spectrum.
        it.bin_index   = BIN_W'($urandom_range(BINS_N - 1));
        it.power       = pick_power();
        it.frame_start = 1'($urandom_range(1));
        it.frame_end   = 1'($urandom_range(1));
        it.receiving   = 1'($urandom_range(1));
        send_bin(it);
        sent++;
      end else begin
        len  = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        // Most frames stay in a narrow band so that histories build up.
        base = ($urandom_range(7) == 0) ? $urandom_range(BINS_N - 1) : $urandom_range(span - 1);
        if (base + len > BINS_N) base = BINS_N - len;
        rx         = ($urandom_range(99) < rx_pct);
        broken     = ($urandom_range(99) < 6);
        drop_start = 1'($urandom_range(1));
        for (int i = 0; i < len; i++) begin
          it.bin_index   = BIN_W'(base + i);
          it.power       = pick_power();
          it.frame_start = (i == 0) && !(broken && drop_start);
          it.frame_end   = (i == len - 1) && !(broken && !drop_start);
          it.receiving   = it.frame_start ? rx : 1'($urandom_range(1));
          send_bin(it);
        end
        sent += len;
      end
    end
  endtask

  // A run of quiet frames that steps the idle counter onto idle_frames.
  task automatic idle_soak();
    in_item_t it;
    soak_mode = 1'b1;
    // A receiving frame restarts the idle count.
    it = '{bin_index: BIN_W'(BINS_N - 1), power: 32'hFFFF_FFFF,
           frame_start: 1'b1, frame_end: 1'b1, receiving: 1'b1};
    send_bin(it);
    // Full-scale power in every slot takes the top bin's sum to its maximum.
    it.receiving = 1'b0;
    repeat (HIST_DEPTH + 1) send_bin(it);
    // Quiet frames on both sides of the clear.
    repeat (8) begin
      it.bin_index = BIN_W'($urandom_range(BINS_N - 1));
      it.power     = pick_power();
      send_bin(it);
    end
    soak_mode = 1'b0;
  endtask

  // Compare one popped result with the oldest expectation.
  task automatic check_average(out_item_t got);
    out_item_t want;
    if (pending_averages.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: bin %0d average %h last %0b",
                 got.bin_out, got.average, got.frame_last);
    end else begin
      want = pending_averages.pop_front();
      if (got.bin_out !== want.bin_out || got.average !== want.average ||
          got.frame_last !== want.frame_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected bin %0d average %h last %0b, got bin %0d average %h last %0b",
                   want.bin_out, want.average, want.frame_last,
                   got.bin_out, got.average, got.frame_last);
      end
    end
  endtask

  // Result side: pop with random stalls, and check every accepted result.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_average(result_o);
      if (rx_stall_left != 0) begin
        rx_stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!rx_calm && $urandom_range(99) < 25) rx_stall_left = pick_gap();
      end
      if ($urandom_range(199) == 0) rx_calm = !rx_calm;
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Main sequence.
  initial begin
    wipe_history();
    hist_slot     = '0;
    idle_run      = '0;
    idle_frames_q = IDLE_FRAMES_RST;

    // Directed table, starting from the cleared state with the slot at zero.
    directed_bins.push_back(dir_row(0,     32'h0000_0000, 1, 0, 1, 1, 32'h0000_0000));
    directed_bins.push_back(dir_row(511,   32'hFFFF_FFFF, 0, 0, 0, 1, 32'h0FFF_FFFF));
    directed_bins.push_back(dir_row(1,     32'h0000_0010, 0, 0, 0, 1, 32'h0000_0001));
    // Truncation, and a receiving flag that is ignored without a frame start.
    directed_bins.push_back(dir_row(2,     32'h0000_000F, 0, 0, 1, 1, 32'h0000_0000));
    // Rewriting the same slot leaves the sum unchanged; the frame ends here.
    directed_bins.push_back(dir_row(511,   32'hFFFF_FFFF, 0, 1, 0, 1, 32'h0FFF_FFFF));
    directed_bins.push_back(dir_row(511,   32'hFFFF_FFFF, 1, 0, 1, 1, 32'h1FFF_FFFF));
    directed_bins.push_back(dir_row(9'h155, 32'hAAAA_AAAA, 0, 0, 0, 0, '0));
    directed_bins.push_back(dir_row(9'h0AA, 32'h5555_5555, 0, 1, 0, 0, '0));
    // Start and end on the same request, on a quiet frame.
    directed_bins.push_back(dir_row(1,     32'h0000_0000, 1, 1, 0, 1, 32'h0000_0001));
    directed_bins.push_back(dir_row(9'h100, 32'h8000_0000, 1, 1, 0, 0, '0));
    directed_bins.push_back(dir_row(9'h0FF, 32'h7FFF_FFFF, 1, 0, 1, 0, '0));
    directed_bins.push_back(dir_row(511,   32'h0000_0000, 0, 0, 0, 1, 32'h1FFF_FFFF));
    directed_bins.push_back(dir_row(2,     32'h0000_0001, 0, 1, 0, 0, '0));
    directed_bins.push_back(dir_row(3,     32'hDEAD_BEEF, 1, 1, 1, 0, '0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Typed rows replace the model's expectation with the hand-worked one.
    foreach (directed_bins[i]) begin
      send_bin(directed_bins[i].stim);
      if (directed_bins[i].typed)
        pending_averages[pending_averages.size() - 1].average = directed_bins[i].avg;
    end

    // Random phases under a range of idle_frames settings.
    set_idle_frames(16'd3);
    run_frames(150, 50, 24);
    settle_results();
    run_frames(150, 50, 24);
    set_idle_frames(16'd1);
    run_frames(200, 70, 16);
    set_idle_frames(16'd0);
    run_frames(200, 30, 32);
    set_idle_frames(16'd20);
    idle_soak();
    set_idle_frames(16'd2);
    run_frames(400, 40, 24);
    set_idle_frames(16'd5);
    run_frames(250, 50, 64);

    // Drain and allow a few cycles for any stray result.
    settle_results();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && pending_averages.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
